/* src/pac_pkg.sv */
// Shared types and constants of the process admission control unit.
// Holds field widths, status codes, register indexes and the controller/datapath
// command and status structs. Depends on nothing.
package pac_pkg;

  localparam int ID_W      = 8;
  localparam int MEM_W     = 10;
  localparam int RUN_W     = 4;
  localparam int STATUS_W  = 3;
  localparam int TDATA_W   = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 10;
  localparam int ENTRY_W   = ID_W + MEM_W;

  // Reset values of the configuration registers
  localparam logic [RUN_W-1:0] MAX_RUNNING_RST     = RUN_W'(5);
  localparam logic [MEM_W-1:0] MEMORY_CAPACITY_RST = MEM_W'(100);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUNNING     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_CAPACITY = 1'b1;

  // Request kinds carried on the input tuser
  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_KILL   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADMITTED       = 3'd0,
    ST_QUEUED         = 3'd1,
    ST_REJECTED       = 3'd2,
    ST_KILLED         = 3'd3,
    ST_NOT_FOUND      = 3'd4,
    ST_ADMITTED_QUEUE = 3'd5
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;     // latch the request, rewind the slot scan
    logic do_create;   // admit, queue or reject the latched create
    logic scan_step;   // test one running slot against the kill id
    logic head_read;   // read the head of the waiting queue
    logic head_admit;  // move the queue head into a running slot
    logic emit;        // load the pending result into the output register
    logic emit_last;   // tlast of that result
  } pac_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_hit;    // current slot holds the kill id
    logic scan_last;   // current slot is the last one
    logic head_ok;     // queue not empty and its head can be admitted
    logic out_free;    // output register can take a result this cycle
  } pac_sts_t;

endpackage

/* src/process_admission_control_unit.sv */
// Process admission control unit, top level.
// Joins the controller (pac_ctrl) and the datapath (pac_dpath). Depends on pac_pkg.
//
// Use:
//   s_* carries one request: s_tuser is the kind (create or kill), s_tdata holds
//   process_id in bits 7:0 and memory_need in bits 17:8. A create gives one result;
//   a kill gives a killed or not-found result, then one result for each job
//   admitted from the waiting queue. m_tlast marks the final result of a request.
//   cfg_* writes max_running (index 0) or memory_capacity (index 1); always ready,
//   write only while no request is in flight.
// Sequence:
//   One request at a time. A create passes through a decide step to the result
//   register. A kill scans the running slots (one slot per cycle) until a hit or
//   the last slot, then reads and checks the queue head and emits, and repeats
//   admit, read, check and emit for each job drained from the queue, which reads
//   through the queue RAM's registered port.
// Reset: rst clears all slots, memory use and the queue and restores the
//   register reset values. A stalled m_tready holds the result register and
//   the sequence waits in its emit step; the next request is taken once the
//   final result is loaded.
module process_admission_control_unit #(
  parameter int RUN_SLOTS  = 8,
  parameter int WAIT_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pac_pkg::CFG_W-1:0]       cfg_data,
  // Request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pac_pkg::TDATA_W-1:0]     s_tdata,  // [7:0] process_id, [17:8] memory_need
  input  logic                            s_tuser,  // [0] operation
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pac_pkg::TDATA_W-1:0]     m_tdata,  // [7:0] job_id, [17:8] job_memory
  output logic [pac_pkg::STATUS_W-1:0]    m_tuser,  // [2:0] status
  output logic                            m_tlast
);
  import pac_pkg::*;

  pac_cmd_t cmd;
  pac_sts_t sts;

  assign cfg_ready = 1'b1;

  pac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pac_dpath #(
    .RUN_SLOTS  (RUN_SLOTS),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* src/pac_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the waiting queue. Depends on nothing.
module pac_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/pac_ctrl.sv */
// Controller state machine of the process admission control unit.
// Sequences create, kill scan, queue drain and result delivery.
// Depends on pac_pkg.
module pac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  output logic              s_tready,
  input  pac_pkg::pac_sts_t sts,
  output pac_pkg::pac_cmd_t cmd
);
  import pac_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CREATE,
    SCAN,
    HEAD_RD,
    HEAD_CHK,
    EMIT,
    HEAD_ADM
  } state_t;

  state_t state;
  logic   last_flag;

  assign s_tready = (state == IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd            = '0;
    cmd.take_in    = (state == IDLE) && s_tvalid;
    cmd.do_create  = (state == CREATE);
    cmd.scan_step  = (state == SCAN);
    cmd.head_read  = (state == HEAD_RD);
    cmd.head_admit = (state == HEAD_ADM);
    cmd.emit       = (state == EMIT) && sts.out_free;
    cmd.emit_last  = last_flag;
  end

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      last_flag <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= (s_tuser == OP_KILL) ? SCAN : CREATE;
          end
        end
        CREATE: begin
          last_flag <= 1'b1;
          state     <= EMIT;
        end
        SCAN: begin
          if (sts.scan_hit || sts.scan_last) begin
            state <= HEAD_RD;
          end
        end
        HEAD_RD: begin
          state <= HEAD_CHK;
        end
        HEAD_CHK: begin
          last_flag <= !sts.head_ok;
          state     <= EMIT;
        end
        EMIT: begin
          if (sts.out_free) begin
            state <= last_flag ? IDLE : HEAD_ADM;
          end
        end
        HEAD_ADM: begin
          state <= HEAD_RD;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* src/pac_dpath.sv */
// Datapath of the process admission control unit: configuration registers,
// running slots, memory accounting, waiting queue and output register.
// Depends on pac_pkg and pac_ram.
module pac_dpath #(
  parameter int RUN_SLOTS  = 8,
  parameter int WAIT_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [pac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pac_pkg::CFG_W-1:0]       cfg_data,
  input  logic [pac_pkg::TDATA_W-1:0]     s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pac_pkg::TDATA_W-1:0]     m_tdata,
  output logic [pac_pkg::STATUS_W-1:0]    m_tuser,
  output logic                            m_tlast,
  input  pac_pkg::pac_cmd_t               cmd,
  output pac_pkg::pac_sts_t               sts
);
  import pac_pkg::*;

  localparam int SLOT_W  = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
  localparam int CNT_W   = $clog2(RUN_SLOTS + 1);
  localparam int WAIT_AW = $clog2(WAIT_DEPTH);
  localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);

  // Configuration
  logic [RUN_W-1:0] max_running;
  logic [MEM_W-1:0] memory_capacity;

  // Latched request
  logic [ID_W-1:0]  in_id;
  logic [MEM_W-1:0] in_need;

  // Running slots and accounting
  logic [RUN_SLOTS-1:0] slot_valid;
  logic [ID_W-1:0]      running_ids    [RUN_SLOTS];
  logic [MEM_W-1:0]     running_memory [RUN_SLOTS];
  logic [MEM_W-1:0]     used_memory;
  logic [CNT_W-1:0]     running_count;
  logic [SLOT_W-1:0]    scan;

  // Waiting queue
  logic [WAIT_AW-1:0] waiting_head;
  logic [WCNT_W-1:0]  waiting_count;
  logic [ENTRY_W-1:0] head_entry;
  logic [WAIT_AW-1:0] tail;
  logic [WCNT_W:0]    tail_sum;
  logic [WAIT_AW-1:0] head_next;

  // Pending result and output register
  status_t          pend_status;
  logic [ID_W-1:0]  pend_id;
  logic [MEM_W-1:0] pend_mem;
  logic             out_valid;
  status_t          out_status;
  logic [ID_W-1:0]  out_id;
  logic [MEM_W-1:0] out_mem;
  logic             out_last;

  // Admission check shared by create and queue drain
  logic [MEM_W-1:0]  need_sel;
  logic [ID_W-1:0]   head_id;
  logic [MEM_W-1:0]  head_mem;
  logic [MEM_W:0]    mem_sum;
  logic              run_ok;
  logic              fits;
  logic              can_admit;
  logic              fifo_full;
  logic [SLOT_W-1:0] free_slot;
  logic              scan_hit;
  logic              scan_last;
  logic [MEM_W-1:0]  scan_mem;

  assign head_id  = head_entry[MEM_W +: ID_W];
  assign head_mem = head_entry[MEM_W-1:0];
  assign need_sel = cmd.do_create ? in_need : head_mem;
  assign mem_sum  = {1'b0, used_memory} + {1'b0, need_sel};
  assign fits     = mem_sum <= {1'b0, memory_capacity};
  assign run_ok   = (32'(running_count) < 32'(max_running)) &&
                    (32'(running_count) < RUN_SLOTS);
  assign can_admit = run_ok && fits;
  assign fifo_full = (waiting_count == WCNT_W'(WAIT_DEPTH));

  // Lowest free running slot
  always_comb begin
    free_slot = '0;
    for (int i = RUN_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Queue tail and head advance with wrap at any depth
  assign tail_sum  = (WCNT_W+1)'(waiting_head) + (WCNT_W+1)'(waiting_count);
  assign tail      = (tail_sum >= (WCNT_W+1)'(WAIT_DEPTH)) ?
                     WAIT_AW'(tail_sum - (WCNT_W+1)'(WAIT_DEPTH)) : WAIT_AW'(tail_sum);
  assign head_next = (waiting_head == WAIT_AW'(WAIT_DEPTH - 1)) ?
                     '0 : waiting_head + 1'b1;

  // Kill scan, one slot per cycle
  assign scan_hit  = slot_valid[scan] && (running_ids[scan] == in_id);
  assign scan_last = (scan == SLOT_W'(RUN_SLOTS - 1));
  assign scan_mem  = running_memory[scan];

  always_comb begin
    sts           = '0;
    sts.scan_hit  = scan_hit;
    sts.scan_last = scan_last;
    sts.head_ok   = (waiting_count != '0) && can_admit;
    sts.out_free  = !out_valid || m_tready;
  end

  pac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (cmd.do_create && !can_admit && !fifo_full),
    .waddr (tail),
    .wdata ({in_id, in_need}),
    .re    (cmd.head_read),
    .raddr (waiting_head),
    .rdata (head_entry)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_running     <= MAX_RUNNING_RST;
      memory_capacity <= MEMORY_CAPACITY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_RUNNING:     max_running     <= cfg_data[RUN_W-1:0];
        CFG_MEMORY_CAPACITY: memory_capacity <= cfg_data[MEM_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the request; the scan is rewound in the block below
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_id   <= s_tdata[ID_W-1:0];
      in_need <= s_tdata[ID_W +: MEM_W];
    end
  end

  // Slots, accounting, queue pointers and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      used_memory   <= '0;
      running_count <= '0;
      waiting_head  <= '0;
      waiting_count <= '0;
      scan          <= '0;
    end else begin
      if (cmd.take_in) begin
        scan <= '0;
      end
      if (cmd.do_create) begin
        pend_id  <= in_id;
        pend_mem <= in_need;
        if (can_admit) begin
          slot_valid[free_slot]     <= 1'b1;
          running_ids[free_slot]    <= in_id;
          running_memory[free_slot] <= in_need;
          used_memory               <= MEM_W'(mem_sum);
          running_count             <= running_count + 1'b1;
          pend_status               <= ST_ADMITTED;
        end else if (!fifo_full) begin
          waiting_count <= waiting_count + 1'b1;
          pend_status   <= ST_QUEUED;
        end else begin
          pend_status <= ST_REJECTED;
        end
      end
      if (cmd.scan_step) begin
        pend_id <= in_id;
        if (scan_hit) begin
          slot_valid[scan] <= 1'b0;
          used_memory      <= (used_memory >= scan_mem) ? used_memory - scan_mem : '0;
          if (running_count != '0) begin
            running_count <= running_count - 1'b1;
          end
          pend_status <= ST_KILLED;
          pend_mem    <= scan_mem;
        end else if (scan_last) begin
          pend_status <= ST_NOT_FOUND;
          pend_mem    <= '0;
        end else begin
          scan <= scan + 1'b1;
        end
      end
      if (cmd.head_admit) begin
        slot_valid[free_slot]     <= 1'b1;
        running_ids[free_slot]    <= head_id;
        running_memory[free_slot] <= head_mem;
        used_memory               <= MEM_W'(mem_sum);
        running_count             <= running_count + 1'b1;
        waiting_head              <= head_next;
        waiting_count             <= waiting_count - 1'b1;
        pend_status               <= ST_ADMITTED_QUEUE;
        pend_id                   <= head_id;
        pend_mem                  <= head_mem;
      end
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= pend_status;
      out_id     <= pend_id;
      out_mem    <= pend_mem;
      out_last   <= cmd.emit_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {(TDATA_W - ENTRY_W)'(0), out_mem, out_id};
  assign m_tlast  = out_last;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for process_admission_control_unit.
// Holds a job table predictor and a result checker; depends on pac_pkg and the unit RTL.
module tb_top;
  import pac_pkg::*;

  localparam int RUN_SLOTS  = 8;
  localparam int WAIT_DEPTH = 16;
  localparam int SETTLE     = 20;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    id;
    logic [MEM_W-1:0]   mem;
    logic               last;
  } job_result_t;

  // Job table predictor and the results it still owes
  class job_board;
    bit                 slot_used[RUN_SLOTS];
    bit [ID_W-1:0]      slot_id[RUN_SLOTS];
    bit [MEM_W-1:0]     slot_mem[RUN_SLOTS];
    int                 used_mem;
    int                 run_cnt;
    bit [ENTRY_W-1:0]   waiting[$];
    bit [RUN_W-1:0]     max_run;
    bit [MEM_W-1:0]     mem_cap;
    job_result_t        owed[$];
    int                 errors;

    function new();
      foreach (slot_used[s]) slot_used[s] = 1'b0;
      used_mem = 0;
      run_cnt  = 0;
      max_run  = MAX_RUNNING_RST;
      mem_cap  = MEMORY_CAPACITY_RST;
      errors   = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_MAX_RUNNING) max_run = val[RUN_W-1:0];
      else mem_cap = val;
    endfunction

    // Limit saturates at the slot count
    function bit room_for(int need);
      int lim;
      lim = (max_run > RUN_SLOTS) ? RUN_SLOTS : max_run;
      return (run_cnt < lim) && (used_mem + need <= mem_cap);
    endfunction

    // Take the lowest free slot
    function void place(bit [ID_W-1:0] id, bit [MEM_W-1:0] need);
      for (int s = 0; s < RUN_SLOTS; s++) begin
        if (!slot_used[s]) begin
          slot_used[s] = 1'b1;
          slot_id[s]   = id;
          slot_mem[s]  = need;
          used_mem     = used_mem + need;
          run_cnt++;
          return;
        end
      end
    endfunction

    function void owe(status_t st, bit [ID_W-1:0] id, bit [MEM_W-1:0] mem);
      job_result_t r;
      r.status = st;
      r.id     = id;
      r.mem    = mem;
      r.last   = 1'b0;
      owed.push_back(r);
    endfunction

    function void note_request(logic op, logic [ID_W-1:0] id, logic [MEM_W-1:0] need);
      bit               hit;
      bit [ENTRY_W-1:0] head;
      hit = 1'b0;
      if (op == OP_CREATE) begin
        if (room_for(need)) begin
          place(id, need);
          owe(ST_ADMITTED, id, need);
        end else if (waiting.size() < WAIT_DEPTH) begin
          waiting.push_back({id, need});
          owe(ST_QUEUED, id, need);
        end else begin
          owe(ST_REJECTED, id, need);
        end
      end else begin
        // Free the lowest matching slot
        for (int s = 0; s < RUN_SLOTS; s++) begin
          if (!hit && slot_used[s] && slot_id[s] == id) begin
            hit          = 1'b1;
            slot_used[s] = 1'b0;
            used_mem     = (used_mem >= slot_mem[s]) ? used_mem - slot_mem[s] : 0;
            if (run_cnt > 0) run_cnt--;
            owe(ST_KILLED, id, slot_mem[s]);
          end
        end
        if (!hit) owe(ST_NOT_FOUND, id, '0);
        // Drain the queue head while it fits
        while (waiting.size() > 0 && room_for(waiting[0][MEM_W-1:0])) begin
          head = waiting.pop_front();
          place(head[ENTRY_W-1:MEM_W], head[MEM_W-1:0]);
          owe(ST_ADMITTED_QUEUE, head[ENTRY_W-1:MEM_W], head[MEM_W-1:0]);
        end
      end
      owed[owed.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string what, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(job_result_t got);
      job_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d id %0d mem %0d last %0b",
                 $time, got.status, got.id, got.mem, got.last);
        return;
      end
      want = owed.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("job_id", want.id, got.id);
      compare_field("job_memory", want.mem, got.mem);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_RUNNING;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tuser = OP_CREATE;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic               m_tlast;

  int       src_idle_pct  = 0;
  int       sink_stall_pct = 0;
  logic     hold_tgl  = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;
  job_board board;

  process_admission_control_unit #(
    .RUN_SLOTS (RUN_SLOTS),
    .WAIT_DEPTH(WAIT_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Result sink: random stalls, plus a long hold-off on each toggle
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Observe config writes, requests and results at each edge
  always @(posedge clk) begin
    if (!rst && board != null) begin
      if (cfg_valid && cfg_ready) board.apply_cfg(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        board.note_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W+MEM_W-1:ID_W]);
      if (m_tvalid && m_tready)
        board.check_result({status_t'(m_tuser), m_tdata[ID_W-1:0],
                            m_tdata[ID_W+MEM_W-1:ID_W], m_tlast});
    end
  end

  // Offer one request; valid stays high when the next follows at once
  task automatic send_req(logic op, logic [ID_W-1:0] id, logic [MEM_W-1:0] need);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(TDATA_W-ID_W-MEM_W){1'b0}}, need, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every owed result has arrived
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic [RUN_W-1:0] max_run, logic [MEM_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_RUNNING;
    cfg_data  <= CFG_W'(max_run);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MEMORY_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Random mix: ids mostly from a small pool so kills hit running jobs
  task automatic send_random(int n);
    logic             op;
    logic [ID_W-1:0]  id;
    logic [MEM_W-1:0] need;
    int               pick;
    for (int k = 0; k < n; k++) begin
      op   = ($urandom_range(99) < 40) ? OP_KILL : OP_CREATE;
      id   = ($urandom_range(99) < 80) ? ID_W'($urandom_range(15)) : ID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 70) need = MEM_W'($urandom_range(60));
      else if (pick < 90) need = MEM_W'($urandom_range(300));
      else need = MEM_W'($urandom);
      send_req(op, id, need);
    end
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Reset limits: exact fit, zero need, duplicate ids, create ahead of queue
    send_req(OP_CREATE, 8'h01, 10'd30);
    send_req(OP_CREATE, 8'hFF, 10'd70);
    send_req(OP_CREATE, 8'h01, 10'd0);
    send_req(OP_CREATE, 8'h80, 10'd1023);
    send_req(OP_CREATE, 8'h02, 10'd0);
    send_req(OP_KILL,   8'h55, 10'd0);
    send_req(OP_KILL,   8'h01, 10'h3FF);
    send_req(OP_KILL,   8'h01, 10'd0);
    send_req(OP_KILL,   8'hFF, 10'd0);
    send_req(OP_KILL,   8'h02, 10'd0);
    drain();

    // Zero run limit: everything queues until the queue is full
    set_config(4'd0, 10'd1023);
    for (int k = 0; k < WAIT_DEPTH - 1; k++)
      send_req(OP_CREATE, ID_W'(8'h10 + k), (k < 7) ? 10'd0 : MEM_W'($urandom));
    send_req(OP_CREATE, 8'hEE, 10'h155);
    send_req(OP_KILL,   8'hAA, 10'd0);
    drain();

    // Saturated limit: one kill drains a full set of slots from the queue
    set_config(4'd15, 10'd1023);
    send_req(OP_KILL, 8'h33, 10'h3FF);
    send_random(100);
    drain();

    // Single slot, no memory; sender idles
    set_config(4'd1, 10'd0);
    src_idle_pct = 63;
    send_random(70);
    drain();

    // Receiver stalls, with a long hold-off that backs up the input
    set_config(4'd8, 10'd100);
    src_idle_pct   = 0;
    sink_stall_pct = 63;
    send_random(40);
    hold_tgl <= ~hold_tgl;
    send_random(60);
    drain();

    // Both sides idle a little
    set_config(4'd5, 10'd300);
    src_idle_pct   = 15;
    sink_stall_pct = 15;
    send_random(100);
    drain();

    // Full rate with one more hold-off
    set_config(4'd3, 10'd512);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_tgl <= ~hold_tgl;
    send_random(100);
    drain();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* process_admission_control_unit.f */
src/pac_pkg.sv
src/pac_ram.sv
src/pac_ctrl.sv
src/pac_dpath.sv
src/process_admission_control_unit.sv
tb/tb_top.sv
